// ===== rtl/core/connected_address_matcher_unit_defines.svh =====
// assertion macros shared by the matcher modules
// each use expects clk and rst_n in scope
`ifndef CONNECTED_ADDRESS_MATCHER_UNIT_DEFINES_SVH
`define CONNECTED_ADDRESS_MATCHER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cam_pkg.sv =====
package cam_pkg;

  // default table depths
  localparam int ENTRY_SLOTS_DEF = 64;
  localparam int IFACE_COUNT_DEF = 16;
  localparam int VIF_COUNT_DEF   = 64;

  // fixed field widths
  localparam int FUNC_W = 3;
  localparam int SLOT_W = 6;
  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;
  localparam int IFX_W  = 4;
  localparam int VFX_W  = 6;

  // request function codes
  localparam logic [FUNC_W-1:0] FN_WR_ENTRY = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WR_IFACE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WR_VIF   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_OWN      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CONN     = 3'd4;

  // one input request
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_length;
    logic [ADDR_W-1:0] endpoint_address;
    logic              has_peer;
    logic              enable;
    logic              carrier_down;
    logic [IFX_W-1:0]  iface_index;
    logic [VFX_W-1:0]  vif_idx;
  } item_t;

  // one result
  typedef struct packed {
    logic              found;
    logic [IFX_W-1:0]  match_iface;
    logic [VFX_W-1:0]  match_vif;
    logic [SLOT_W-1:0] match_slot;
  } result_t;

  // stored entry payload
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] peer;
    logic [PLEN_W-1:0] prefix;
    logic [IFX_W-1:0]  ifx;
    logic [VFX_W-1:0]  vfx;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic scan_start;
    logic scan_en;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

  // subnet mask, prefix saturated at 32
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    if (plen >= 6'd32) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> plen);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/cam_datapath.sv =====
`include "connected_address_matcher_unit_defines.svh"

module cam_datapath #(
  parameter int ENTRY_SLOTS = cam_pkg::ENTRY_SLOTS_DEF,
  parameter int IFACE_COUNT = cam_pkg::IFACE_COUNT_DEF,
  parameter int VIF_COUNT   = cam_pkg::VIF_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cam_pkg::item_t      item,
  input  cam_pkg::ctrl_cmd_t  cmd,
  output cam_pkg::dp_sts_t    sts,
  output cam_pkg::result_t    out_res
);

  localparam int ES_W  = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int IF_W  = (IFACE_COUNT > 1) ? $clog2(IFACE_COUNT) : 1;
  localparam int VF_W  = (VIF_COUNT > 1) ? $clog2(VIF_COUNT) : 1;
  localparam int CLR_A = (ENTRY_SLOTS > IFACE_COUNT) ? ENTRY_SLOTS : IFACE_COUNT;
  localparam int CLR_N = (CLR_A > VIF_COUNT) ? CLR_A : VIF_COUNT;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [ES_W:0]    SLOT_END  = (ES_W+1)'(ENTRY_SLOTS);
  localparam logic [ES_W-1:0]  SLOT_LAST = ES_W'(ENTRY_SLOTS - 1);
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);

  // table storage
  cam_pkg::entry_t edata_mem [ENTRY_SLOTS];
  logic [1:0]      eflag_mem [ENTRY_SLOTS];   // {has_peer, enable}
  logic [1:0]      iflag_mem [IFACE_COUNT];   // {carrier_down, enable}
  logic            vflag_mem [VIF_COUNT];

  logic [CLR_W-1:0] clr_cnt_r;
  logic [ES_W:0]    scan_cnt_r;
  logic             v1_r;
  logic             v2_r;
  logic [31:0]      qaddr_r;
  logic             conn_r;

  cam_pkg::entry_t  ed1_r;
  logic [1:0]       ef1_r;
  logic [ES_W-1:0]  slot1_r;
  cam_pkg::entry_t  ed2_r;
  logic [1:0]       ef2_r;
  logic [ES_W-1:0]  slot2_r;
  logic             ok2_r;
  logic [1:0]       if2_r;
  logic             vf2_r;

  cam_pkg::result_t result_r;
  cam_pkg::result_t out_res_r;

  logic             wr_entry;
  logic             wr_iface;
  logic             wr_vif;
  logic             clr_e;
  logic             clr_i;
  logic             clr_v;
  logic             issue;
  logic             own_ok1;
  logic [31:0]      mask;
  logic             live;
  logic             match;
  logic             hit;

  // write and clear decode
  always_comb begin
    wr_entry = cmd.wr_en && (item.func == cam_pkg::FN_WR_ENTRY) &&
               (32'(item.slot) < ENTRY_SLOTS);
    wr_iface = cmd.wr_en && (item.func == cam_pkg::FN_WR_IFACE) &&
               (32'(item.iface_index) < IFACE_COUNT);
    wr_vif   = cmd.wr_en && (item.func == cam_pkg::FN_WR_VIF) &&
               (32'(item.vif_idx) < VIF_COUNT);
    clr_e    = cmd.clr_en && (32'(clr_cnt_r) < ENTRY_SLOTS);
    clr_i    = cmd.clr_en && (32'(clr_cnt_r) < IFACE_COUNT);
    clr_v    = cmd.clr_en && (32'(clr_cnt_r) < VIF_COUNT);
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && (clr_cnt_r != CLR_LAST)) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == CLR_LAST);

  // entry payload memory
  always_ff @(posedge clk) begin
    if (wr_entry) begin
      edata_mem[ES_W'(item.slot)] <= '{addr:   item.address,
                                        peer:   item.endpoint_address,
                                        prefix: item.prefix_length,
                                        ifx:    item.iface_index,
                                        vfx:    item.vif_idx};
    end
  end

  // entry flag memory, swept to zero after reset
  always_ff @(posedge clk) begin
    if (clr_e) begin
      eflag_mem[ES_W'(clr_cnt_r)] <= 2'b00;
    end else if (wr_entry) begin
      eflag_mem[ES_W'(item.slot)] <= {item.has_peer, item.enable};
    end
  end

  // interface flag memory
  always_ff @(posedge clk) begin
    if (clr_i) begin
      iflag_mem[IF_W'(clr_cnt_r)] <= 2'b00;
    end else if (wr_iface) begin
      iflag_mem[IF_W'(item.iface_index)] <= {item.carrier_down, item.enable};
    end
  end

  // vif flag memory
  always_ff @(posedge clk) begin
    if (clr_v) begin
      vflag_mem[VF_W'(clr_cnt_r)] <= 1'b0;
    end else if (wr_vif) begin
      vflag_mem[VF_W'(item.vif_idx)] <= item.enable;
    end
  end

  // scan slot counter and stage valids
  assign issue = cmd.scan_en && (scan_cnt_r < SLOT_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (issue) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      v1_r <= issue;
      v2_r <= v1_r && cmd.scan_en;
    end
  end

  // query capture
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      qaddr_r <= item.address;
      conn_r  <= (item.func == cam_pkg::FN_CONN);
    end
  end

  // stage 1: entry read
  always_ff @(posedge clk) begin
    if (issue) begin
      ed1_r   <= edata_mem[scan_cnt_r[ES_W-1:0]];
      ef1_r   <= eflag_mem[scan_cnt_r[ES_W-1:0]];
      slot1_r <= scan_cnt_r[ES_W-1:0];
    end
  end

  assign own_ok1 = (32'(ed1_r.ifx) < IFACE_COUNT) && (32'(ed1_r.vfx) < VIF_COUNT);

  // stage 2: owner flag reads
  always_ff @(posedge clk) begin
    if (v1_r) begin
      ed2_r   <= ed1_r;
      ef2_r   <= ef1_r;
      slot2_r <= slot1_r;
      ok2_r   <= own_ok1;
      if2_r   <= iflag_mem[IF_W'(ed1_r.ifx)];
      vf2_r   <= vflag_mem[VF_W'(ed1_r.vfx)];
    end
  end

  // liveness and address compare
  always_comb begin
    mask  = cam_pkg::prefix_mask(ed2_r.prefix);
    live  = v2_r && ef2_r[0] && ok2_r && if2_r[0] && !if2_r[1] && vf2_r;
    match = (ed2_r.addr == qaddr_r) ||
            (conn_r && ((ef2_r[1] && (ed2_r.peer == qaddr_r)) ||
                        (((qaddr_r ^ ed2_r.addr) & mask) == '0)));
    hit   = cmd.scan_en && live && match;
  end

  assign sts.scan_hit  = hit;
  assign sts.scan_last = v2_r && (slot2_r == SLOT_LAST);

  // working result, first hit wins
  always_ff @(posedge clk) begin
    if (cmd.wr_en || cmd.scan_start) begin
      result_r <= '0;
    end else if (hit) begin
      result_r <= '{found:       1'b1,
                    match_iface: ed2_r.ifx,
                    match_vif:   ed2_r.vfx,
                    match_slot:  cam_pkg::SLOT_W'(slot2_r)};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= result_r;
    end
  end

  assign out_res = out_res_r;

  `CAM_ASSERT_SAME(a_stage_order, v2_r, $past(v1_r), "stage 2 valid without stage 1")
  `CAM_ASSERT_NEXT(a_scan_restart, cmd.scan_start, (scan_cnt_r == '0) && !v1_r,
                   "scan did not restart from slot zero")

endmodule

// ===== rtl/core/cam_ctrl.sv =====
`include "connected_address_matcher_unit_defines.svh"

module cam_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [cam_pkg::FUNC_W-1:0]   in_func,
  output logic                         in_ready,
  input  logic                         out_ready,
  output logic                         out_valid,
  input  cam_pkg::dp_sts_t             sts,
  output cam_pkg::ctrl_cmd_t           cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   is_lookup;

  assign is_lookup = (in_func == cam_pkg::FN_OWN) || (in_func == cam_pkg::FN_CONN);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (is_lookup) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // output valid follows loads and takes
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CAM_ASSERT_SAME(a_clr_quiet, cmd.clr_en, !cmd.wr_en && !cmd.scan_en && !in_ready,
                   "table activity during clearing sweep")
  `CAM_ASSERT_NEXT(a_lookup_scans, in_valid && in_ready && is_lookup, state_r == ST_SCAN,
                   "lookup request did not start a scan")
  `CAM_ASSERT_NEXT(a_scan_stops, (state_r == ST_SCAN) && (sts.scan_hit || sts.scan_last),
                   state_r == ST_RESP, "scan did not stop on hit or last slot")

endmodule

// ===== rtl/core/connected_address_matcher_unit.sv =====
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  in_tuser func, in_tdata entry/query fields
// out_      out  out_tvalid/out_tready out_tuser found, in out_tdata match fields
//
// after reset a clearing sweep over max(ENTRY_SLOTS, IFACE_COUNT, VIF_COUNT)
// table addresses zeroes the flag tables; in_tready stays low meanwhile
// a write request is answered with an empty result, loaded once the output register is free
// a lookup reads one entry slot per cycle, then registers the owner flag reads and compares;
// the scan stops on the first hit or the last slot, then waits for a free output register
// one request in work at a time; a new one is taken while a result waits on out_tready
module connected_address_matcher_unit #(
  parameter int ENTRY_SLOTS = cam_pkg::ENTRY_SLOTS_DEF,
  parameter int IFACE_COUNT = cam_pkg::IFACE_COUNT_DEF,
  parameter int VIF_COUNT   = cam_pkg::VIF_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slot[5:0] address[37:6] prefix_length[43:38] endpoint_address[75:44]
  // has_peer[76] enable[77] carrier_down[78] iface_index[82:79]
  // vif_idx[88:83] zero[95:89]
  input  logic [95:0] in_tdata,
  // func[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // match_iface[3:0] match_vif[9:4] match_slot[15:10]
  output logic [15:0] out_tdata,
  // found[0]
  output logic [0:0]  out_tuser
);

  cam_pkg::item_t     item;
  cam_pkg::ctrl_cmd_t cmd;
  cam_pkg::dp_sts_t   sts;
  cam_pkg::result_t   res;

  // unpack request fields
  always_comb begin
    item.func             = in_tuser;
    item.slot             = in_tdata[5:0];
    item.address          = in_tdata[37:6];
    item.prefix_length    = in_tdata[43:38];
    item.endpoint_address = in_tdata[75:44];
    item.has_peer         = in_tdata[76];
    item.enable           = in_tdata[77];
    item.carrier_down     = in_tdata[78];
    item.iface_index      = in_tdata[82:79];
    item.vif_idx          = in_tdata[88:83];
  end

  cam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cam_datapath #(
    .ENTRY_SLOTS (ENTRY_SLOTS),
    .IFACE_COUNT (IFACE_COUNT),
    .VIF_COUNT   (VIF_COUNT)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (res)
  );

  // pack result
  assign out_tdata = {res.match_slot, res.match_vif, res.match_iface};
  assign out_tuser = res.found;

endmodule

// ===== test/tb_connected_address_matcher_unit.sv =====
`timescale 1ns / 100ps

module tb_connected_address_matcher_unit;

  localparam int CLK_HALF_NS    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 460;
  localparam int PHASE_COUNT    = 4;
  localparam int TAIL_CYCLES    = cam_pkg::ENTRY_SLOTS_DEF + 16;

  // function codes the block treats as no-ops
  localparam logic [cam_pkg::FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [cam_pkg::FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  // table of stored entries and flags, mirrored from the requests sent
  class matcher_scoreboard;
    bit [cam_pkg::ADDR_W-1:0] ent_addr [cam_pkg::ENTRY_SLOTS_DEF];
    bit [cam_pkg::ADDR_W-1:0] ent_peer [cam_pkg::ENTRY_SLOTS_DEF];
    bit [cam_pkg::PLEN_W-1:0] ent_prefix [cam_pkg::ENTRY_SLOTS_DEF];
    bit                       ent_en [cam_pkg::ENTRY_SLOTS_DEF];
    bit                       ent_has_peer [cam_pkg::ENTRY_SLOTS_DEF];
    bit [cam_pkg::IFX_W-1:0]  ent_ifx [cam_pkg::ENTRY_SLOTS_DEF];
    bit [cam_pkg::VFX_W-1:0]  ent_vfx [cam_pkg::ENTRY_SLOTS_DEF];
    bit                       if_en [cam_pkg::IFACE_COUNT_DEF];
    bit                       if_nocarrier [cam_pkg::IFACE_COUNT_DEF];
    bit                       vif_en [cam_pkg::VIF_COUNT_DEF];
    cam_pkg::result_t         awaited_q [$];
    int                       failures = 0;

    // prefix length to subnet mask, lengths above the width saturate
    function bit [cam_pkg::ADDR_W-1:0] subnet_mask(bit [cam_pkg::PLEN_W-1:0] plen);
      if (plen == 0) return '0;
      if (plen >= cam_pkg::ADDR_W) return '1;
      return ~({cam_pkg::ADDR_W{1'b1}} >> plen);
    endfunction

    function bit entry_live(int s);
      return ent_en[s] && if_en[ent_ifx[s]] && !if_nocarrier[ent_ifx[s]] && vif_en[ent_vfx[s]];
    endfunction

    // update the tables and work out the answer of one request
    function cam_pkg::result_t apply_request(cam_pkg::item_t req);
      cam_pkg::result_t         r;
      bit                       hit;
      bit [cam_pkg::ADDR_W-1:0] m;
      r = '0;
      case (req.func)
        cam_pkg::FN_WR_ENTRY: begin
          ent_addr[req.slot]     = req.address;
          ent_peer[req.slot]     = req.endpoint_address;
          ent_prefix[req.slot]   = req.prefix_length;
          ent_en[req.slot]       = req.enable;
          ent_has_peer[req.slot] = req.has_peer;
          ent_ifx[req.slot]      = req.iface_index;
          ent_vfx[req.slot]      = req.vif_idx;
        end
        cam_pkg::FN_WR_IFACE: begin
          if_en[req.iface_index]        = req.enable;
          if_nocarrier[req.iface_index] = req.carrier_down;
        end
        cam_pkg::FN_WR_VIF: begin
          vif_en[req.vif_idx] = req.enable;
        end
        cam_pkg::FN_OWN, cam_pkg::FN_CONN: begin
          // lowest live slot that matches wins
          for (int s = 0; s < cam_pkg::ENTRY_SLOTS_DEF; s++) begin
            if (!r.found && entry_live(s)) begin
              m = subnet_mask(ent_prefix[s]);
              hit = (ent_addr[s] == req.address);
              if (req.func == cam_pkg::FN_CONN) begin
                hit = hit || (ent_has_peer[s] && ent_peer[s] == req.address) ||
                      ((req.address & m) == (ent_addr[s] & m));
              end
              if (hit) begin
                r.found       = 1'b1;
                r.match_iface = ent_ifx[s];
                r.match_vif   = ent_vfx[s];
                r.match_slot  = s[cam_pkg::SLOT_W-1:0];
              end
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(cam_pkg::item_t req);
      awaited_q.push_back(apply_request(req));
    endfunction

    function void check_result(cam_pkg::result_t got);
      cam_pkg::result_t want;
      if (awaited_q.size() == 0) begin
        $error("result with no request outstanding: found %0h iface %0h vif %0h slot %0h",
               got.found, got.match_iface, got.match_vif, got.match_slot);
        failures++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0h, got %0h", want.found, got.found);
        failures++;
      end
      if (got.match_iface !== want.match_iface) begin
        $error("match_iface: expected %0h, got %0h", want.match_iface, got.match_iface);
        failures++;
      end
      if (got.match_vif !== want.match_vif) begin
        $error("match_vif: expected %0h, got %0h", want.match_vif, got.match_vif);
        failures++;
      end
      if (got.match_slot !== want.match_slot) begin
        $error("match_slot: expected %0h, got %0h", want.match_slot, got.match_slot);
        failures++;
      end
    endfunction

    function int outstanding();
      return awaited_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  matcher_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int send_pct_by_phase [PHASE_COUNT] = '{0, 76, 0, 15};
  int recv_pct_by_phase [PHASE_COUNT] = '{0, 0, 76, 15};
  bit holdoff_req = 1'b0;
  int holdoff_left = 0;
  int cycle_count = 0;

  connected_address_matcher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side ready, random stalls plus one long hold-off on demand
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req  <= 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    cam_pkg::result_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.found       = out_tuser[0];
      got.match_iface = out_tdata[3:0];
      got.match_vif   = out_tdata[9:4];
      got.match_slot  = out_tdata[15:10];
      sb.check_result(got);
    end
  end

  // every field random, callers override what matters
  function automatic cam_pkg::item_t random_fields();
    cam_pkg::item_t r;
    r.func             = cam_pkg::FN_WR_ENTRY;
    r.slot             = cam_pkg::SLOT_W'($urandom_range(cam_pkg::ENTRY_SLOTS_DEF - 1));
    r.address          = $urandom;
    r.prefix_length    = cam_pkg::PLEN_W'($urandom_range((1 << cam_pkg::PLEN_W) - 1));
    r.endpoint_address = $urandom;
    r.has_peer         = 1'($urandom_range(1));
    r.enable           = 1'($urandom_range(1));
    r.carrier_down     = 1'($urandom_range(1));
    r.iface_index      = cam_pkg::IFX_W'($urandom_range(cam_pkg::IFACE_COUNT_DEF - 1));
    r.vif_idx          = cam_pkg::VFX_W'($urandom_range(cam_pkg::VIF_COUNT_DEF - 1));
    return r;
  endfunction

  function automatic cam_pkg::item_t make_entry(int slot, bit [cam_pkg::ADDR_W-1:0] addr,
                                                int plen, bit [cam_pkg::ADDR_W-1:0] peer,
                                                bit hasp, bit en, int ifx, int vfx);
    cam_pkg::item_t r;
    r                  = random_fields();
    r.func             = cam_pkg::FN_WR_ENTRY;
    r.slot             = cam_pkg::SLOT_W'(slot);
    r.address          = addr;
    r.prefix_length    = cam_pkg::PLEN_W'(plen);
    r.endpoint_address = peer;
    r.has_peer         = hasp;
    r.enable           = en;
    r.iface_index      = cam_pkg::IFX_W'(ifx);
    r.vif_idx          = cam_pkg::VFX_W'(vfx);
    return r;
  endfunction

  function automatic cam_pkg::item_t make_iface(int ifx, bit en, bit nocar);
    cam_pkg::item_t r;
    r              = random_fields();
    r.func         = cam_pkg::FN_WR_IFACE;
    r.iface_index  = cam_pkg::IFX_W'(ifx);
    r.enable       = en;
    r.carrier_down = nocar;
    return r;
  endfunction

  function automatic cam_pkg::item_t make_vif(int vfx, bit en);
    cam_pkg::item_t r;
    r         = random_fields();
    r.func    = cam_pkg::FN_WR_VIF;
    r.vif_idx = cam_pkg::VFX_W'(vfx);
    r.enable  = en;
    return r;
  endfunction

  function automatic cam_pkg::item_t make_query(logic [cam_pkg::FUNC_W-1:0] fn,
                                                bit [cam_pkg::ADDR_W-1:0] addr);
    cam_pkg::item_t r;
    r         = random_fields();
    r.func    = fn;
    r.address = addr;
    return r;
  endfunction

  // mostly prefixes in the usual range of 8 to 32, a few empty or oversized ones
  function automatic int pick_prefix();
    int p;
    p = $urandom_range(99);
    if (p < 4) return 0;
    if (p < 10) return $urandom_range((1 << cam_pkg::PLEN_W) - 1, cam_pkg::ADDR_W + 1);
    return $urandom_range(cam_pkg::ADDR_W, 8);
  endfunction

  // owners mostly from a few interfaces and vifs so entries come alive
  function automatic int pick_iface();
    return ($urandom_range(7) == 0) ? $urandom_range(cam_pkg::IFACE_COUNT_DEF - 1) :
                                      $urandom_range(3);
  endfunction

  function automatic int pick_vif();
    return ($urandom_range(7) == 0) ? $urandom_range(cam_pkg::VIF_COUNT_DEF - 1) :
                                      $urandom_range(7);
  endfunction

  // random request biased toward addresses the table holds
  function automatic cam_pkg::item_t gen_request();
    int                       p;
    int                       s;
    bit [cam_pkg::ADDR_W-1:0] a;
    p = $urandom_range(99);
    s = $urandom_range(cam_pkg::ENTRY_SLOTS_DEF - 1);
    if (p < 18) begin
      a = ($urandom_range(1) != 0) ? $urandom : (sb.ent_addr[s] ^ $urandom_range(255));
      return make_entry($urandom_range(cam_pkg::ENTRY_SLOTS_DEF - 1), a, pick_prefix(),
                        ($urandom_range(1) != 0) ? $urandom : (a ^ $urandom_range(15)),
                        1'($urandom_range(1)), $urandom_range(9) != 0, pick_iface(),
                        pick_vif());
    end
    if (p < 26) return make_iface(pick_iface(), $urandom_range(99) < 85, $urandom_range(99) < 15);
    if (p < 34) return make_vif(pick_vif(), $urandom_range(99) < 85);
    if (p < 96) begin
      p = $urandom_range(99);
      if (p < 40) a = sb.ent_addr[s];
      else if (p < 55) a = sb.ent_peer[s];
      else if (p < 80) a = sb.ent_addr[s] ^ $urandom_range(255);
      else a = $urandom;
      return make_query(($urandom_range(1) != 0) ? cam_pkg::FN_CONN : cam_pkg::FN_OWN, a);
    end
    return make_query(cam_pkg::FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO)), $urandom);
  endfunction

  // offer one request and wait for its handshake
  task automatic send_request(input cam_pkg::item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.func;
    in_tdata  <= {7'b0, req.vif_idx, req.iface_index, req.carrier_down, req.enable,
                  req.has_peer, req.endpoint_address, req.prefix_length,
                  req.address, req.slot};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(req);
  endtask

  // stop offering until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    sb = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // write every slot once, disabled, so no lookup reads unwritten storage
    for (int s = 0; s < cam_pkg::ENTRY_SLOTS_DEF; s++) begin
      send_request(make_entry(s, $urandom, pick_prefix(), $urandom, 1'($urandom_range(1)),
                              1'b0, $urandom_range(cam_pkg::IFACE_COUNT_DEF - 1),
                              $urandom_range(cam_pkg::VIF_COUNT_DEF - 1)));
    end

    // nothing live yet
    send_request(make_query(cam_pkg::FN_OWN, 32'h0000_0000));
    // extreme interfaces and vifs, one interface without carrier
    send_request(make_iface(0, 1'b1, 1'b0));
    send_request(make_iface(cam_pkg::IFACE_COUNT_DEF - 1, 1'b1, 1'b0));
    send_request(make_iface(1, 1'b1, 1'b1));
    send_request(make_vif(0, 1'b1));
    send_request(make_vif(cam_pkg::VIF_COUNT_DEF - 1, 1'b1));
    // extreme addresses, empty prefix, oversized prefix, peers
    send_request(make_entry(0, 32'hFFFF_FFFF, cam_pkg::ADDR_W, 32'h0000_0001, 1'b0, 1'b1,
                            cam_pkg::IFACE_COUNT_DEF - 1, cam_pkg::VIF_COUNT_DEF - 1));
    send_request(make_entry(cam_pkg::ENTRY_SLOTS_DEF - 1, 32'h0000_0000, 0, 32'hFFFF_FFFE,
                            1'b1, 1'b1, 0, 0));
    send_request(make_entry(5, 32'h0A00_0001, (1 << cam_pkg::PLEN_W) - 1, 32'hC0A8_0101,
                            1'b1, 1'b1, 1, 0));
    send_request(make_entry(6, 32'h0A00_0002, 24, 32'hC0A8_0102, 1'b1, 1'b1, 0, 0));
    send_request(make_query(cam_pkg::FN_OWN, 32'hFFFF_FFFF));
    send_request(make_query(cam_pkg::FN_OWN, 32'h0000_0000));
    send_request(make_query(cam_pkg::FN_CONN, 32'h1234_5678));
    send_request(make_query(cam_pkg::FN_CONN, 32'h0A00_00FF));
    send_request(make_query(cam_pkg::FN_CONN, 32'hC0A8_0102));
    send_request(make_query(cam_pkg::FN_OWN, 32'h0A00_0001));
    // unknown function codes
    send_request(make_query(FN_UNUSED_LO, 32'hFFFF_FFFF));
    send_request(make_query(FN_UNUSED_HI, 32'h0A00_0001));
    // carrier comes back, oversized prefix compares as a full mask
    send_request(make_iface(1, 1'b1, 1'b0));
    send_request(make_query(cam_pkg::FN_OWN, 32'h0A00_0001));
    send_request(make_query(cam_pkg::FN_CONN, 32'h0A00_0003));
    // vif off hides the entries owned by vif 0
    send_request(make_vif(0, 1'b0));
    send_request(make_query(cam_pkg::FN_CONN, 32'h0A00_0002));
    send_request(make_query(cam_pkg::FN_CONN, 32'hFFFF_FFFE));
    drain_results();

    // random phases with different idling, drained in between
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      send_idle_pct  = send_pct_by_phase[ph];
      recv_stall_pct = recv_pct_by_phase[ph];
      if (ph == 0) holdoff_req <= 1'b1;
      repeat (ITEMS_PER_PHASE) send_request(gen_request());
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
